// ===== hdl/egsm_pkg.sv =====
package egsm_pkg;

    localparam int NUM_CHANNELS_DEF = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int TIME_W     = 32;
    localparam int LOCKOUT_W  = 20;
    localparam int SAMPLE_W   = 16;
    localparam int GAPS_W     = 16;
    localparam int SCALE_W    = 16;
    localparam int PROD_W     = 48;
    localparam int QUOT_W     = 32;
    localparam int DIV_CNT_W  = 5;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST = 20'd5000;
    localparam logic [SAMPLE_W-1:0]  SAMPLE_RST  = 16'd100;
    localparam logic [GAPS_W-1:0]    GAPS_RST    = 16'd815;
    localparam logic [SCALE_W-1:0]   SCALE_RST   = 16'd600;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_RIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_US   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAPS_Q8      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE  = 3'd5;

    localparam logic [1:0] MODE_EDGE  = 2'd0;
    localparam logic [1:0] MODE_SPEED = 2'd1;
    localparam logic [1:0] MODE_GAPS  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL_NUM,
        ST_MUL_DEN,
        ST_CHK,
        ST_DIV,
        ST_PUT
    } t_state;

    typedef struct packed {
        logic [1:0]        mode;
        logic              channel;
        logic [TIME_W-1:0] now_us;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic              result_channel;
        logic [QUOT_W-1:0] speed_q8;
        logic [TIME_W-1:0] gap_count;
        logic              speed_updated;
    } t_out_item;

endpackage

// ===== hdl/encoder_gap_speed_meter.sv =====
// edge and gap count transactions pass through the evaluation and put states into the output register
// a speed query that recomputes runs two products through one shared
// 16x32 multiplier, a saturation check, then 32 divider steps; it skips the divider when it saturates
// one transaction in flight: the next is taken once the current one reaches the output
// register; an output stall holds the current transaction in the put state
// reset (synchronous, active low) clears all channel state and loads register defaults
module encoder_gap_speed_meter #(
    parameter int NUM_CHANNELS = egsm_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  egsm_pkg::t_in_item                   i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output egsm_pkg::t_out_item                  o_out_item,
    input  logic                                 i_cfg_we,
    input  logic [egsm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [egsm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // configuration
    logic                               r_en_left;
    logic                               r_en_right;
    logic [egsm_pkg::LOCKOUT_W-1:0]     r_lockout;
    logic [egsm_pkg::SAMPLE_W-1:0]      r_sample_ms;
    logic [egsm_pkg::GAPS_W-1:0]        r_gaps_q8;
    logic [egsm_pkg::SCALE_W-1:0]       r_scale;

    // per channel state
    logic [egsm_pkg::TIME_W-1:0]        r_gap_cnt     [NUM_CHANNELS];
    logic [egsm_pkg::TIME_W-1:0]        r_last_pulse  [NUM_CHANNELS];
    logic [egsm_pkg::TIME_W-1:0]        r_last_sample [NUM_CHANNELS];
    logic [egsm_pkg::TIME_W-1:0]        r_cnt_sample  [NUM_CHANNELS];
    logic [egsm_pkg::QUOT_W-1:0]        r_speed_st    [NUM_CHANNELS];

    egsm_pkg::t_state                   r_state;
    egsm_pkg::t_state                   n_state;

    // transaction payload
    logic [1:0]                         r_mode;
    logic [IDX_W-1:0]                   r_ch;
    logic [egsm_pkg::TIME_W-1:0]        r_now_us;
    logic [egsm_pkg::TIME_W-1:0]        r_now_ms;
    logic [egsm_pkg::TIME_W-1:0]        r_gap;
    logic [egsm_pkg::QUOT_W-1:0]        r_speed;
    logic                               r_upd;
    logic [egsm_pkg::TIME_W-1:0]        r_delta;
    logic [egsm_pkg::TIME_W-1:0]        r_diff;
    logic [egsm_pkg::PROD_W-1:0]        r_num;
    logic [egsm_pkg::PROD_W-1:0]        r_den;
    logic [egsm_pkg::PROD_W-1:0]        r_rem;
    logic [egsm_pkg::QUOT_W-1:0]        r_quo;
    logic [egsm_pkg::DIV_CNT_W-1:0]     r_cnt;

    logic                               r_out_valid;
    egsm_pkg::t_out_item                r_out;

    logic [IDX_W-1:0]                   w_ch_idx;
    logic                               w_in_fire;
    logic                               w_put;
    logic                               w_mul_num;

    logic [egsm_pkg::TIME_W-1:0]        w_gap_cur;
    logic [egsm_pkg::TIME_W-1:0]        w_pulse_cur;
    logic [egsm_pkg::TIME_W-1:0]        w_sample_cur;
    logic [egsm_pkg::TIME_W-1:0]        w_cnt_cur;
    logic                               w_enabled;
    logic                               w_pulse_ok;
    logic [egsm_pkg::TIME_W-1:0]        w_diff_ms;
    logic                               w_need_div;
    logic [egsm_pkg::TIME_W-1:0]        w_gap_next;

    logic [egsm_pkg::SCALE_W-1:0]       w_mul_a;
    logic [egsm_pkg::TIME_W-1:0]        w_mul_b;
    logic [egsm_pkg::PROD_W-1:0]        w_prod;

    logic                               w_sat;
    logic [egsm_pkg::PROD_W:0]          w_shift;
    logic [egsm_pkg::PROD_W+1:0]        w_sub;
    logic                               w_ge;
    logic                               w_div_last;

    // channel select: forced to channel 0 with a single channel, else the item's channel bit
    always_comb begin
        if (NUM_CHANNELS == 1) begin
            w_ch_idx = '0;
        end else begin
            w_ch_idx = IDX_W'(i_in_item.channel);
        end
    end

    // channel state lookup and item decision
    always_comb begin
        w_gap_cur    = r_gap_cnt[r_ch];
        w_pulse_cur  = r_last_pulse[r_ch];
        w_sample_cur = r_last_sample[r_ch];
        w_cnt_cur    = r_cnt_sample[r_ch];
        w_enabled    = (r_ch == '0) ? r_en_left : r_en_right;
        w_pulse_ok   = (r_now_us - w_pulse_cur) >
                       {{(egsm_pkg::TIME_W-egsm_pkg::LOCKOUT_W){1'b0}}, r_lockout};
        w_diff_ms    = r_now_ms - w_sample_cur;
        w_need_div   = (r_mode == egsm_pkg::MODE_SPEED) &&
                       (w_diff_ms > {{(egsm_pkg::TIME_W-egsm_pkg::SAMPLE_W){1'b0}}, r_sample_ms});
        w_gap_next   = w_gap_cur;
        if (r_mode == egsm_pkg::MODE_EDGE) begin
            if (!w_enabled) begin
                w_gap_next = '0;
            end else if (w_pulse_ok) begin
                w_gap_next = w_gap_cur + 1'b1;
            end
        end
    end

    // shared multiplier: scale*delta, then gaps*diff
    assign w_mul_a = w_mul_num ? r_scale : r_gaps_q8;
    assign w_mul_b = w_mul_num ? r_delta : r_diff;
    assign w_prod  = egsm_pkg::PROD_W'(w_mul_a) * egsm_pkg::PROD_W'(w_mul_b);

    // saturate when den is zero, or when the quotient overflows 32 bits: scale*delta >= den * 2^16
    assign w_sat = (r_den == '0) ||
                   ({{egsm_pkg::SCALE_W{1'b0}}, r_num} >= {r_den, {egsm_pkg::SCALE_W{1'b0}}});

    // restoring divider step
    assign w_shift    = {r_rem, r_quo[egsm_pkg::QUOT_W-1]};
    assign w_sub      = {1'b0, w_shift} - {2'b00, r_den};
    assign w_ge       = !w_sub[egsm_pkg::PROD_W+1];
    assign w_div_last = (r_cnt == egsm_pkg::DIV_CNT_W'(egsm_pkg::QUOT_W - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            egsm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = egsm_pkg::ST_EVAL;
                end
            end
            egsm_pkg::ST_EVAL: begin
                n_state = w_need_div ? egsm_pkg::ST_MUL_NUM : egsm_pkg::ST_PUT;
            end
            egsm_pkg::ST_MUL_NUM: begin
                n_state = egsm_pkg::ST_MUL_DEN;
            end
            egsm_pkg::ST_MUL_DEN: begin
                n_state = egsm_pkg::ST_CHK;
            end
            egsm_pkg::ST_CHK: begin
                n_state = w_sat ? egsm_pkg::ST_PUT : egsm_pkg::ST_DIV;
            end
            egsm_pkg::ST_DIV: begin
                if (w_div_last) begin
                    n_state = egsm_pkg::ST_PUT;
                end
            end
            egsm_pkg::ST_PUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = egsm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = egsm_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = (r_state != egsm_pkg::ST_IDLE);
        w_in_fire  = (r_state == egsm_pkg::ST_IDLE) && i_in_valid;
        w_put      = (r_state == egsm_pkg::ST_PUT) && (!r_out_valid || !i_out_stall);
        w_mul_num  = (r_state == egsm_pkg::ST_MUL_NUM);
    end

    // control, configuration and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= egsm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_en_left   <= 1'b0;
            r_en_right  <= 1'b0;
            r_lockout   <= egsm_pkg::LOCKOUT_RST;
            r_sample_ms <= egsm_pkg::SAMPLE_RST;
            r_gaps_q8   <= egsm_pkg::GAPS_RST;
            r_scale     <= egsm_pkg::SCALE_RST;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_gap_cnt[i]     <= '0;
                r_last_pulse[i]  <= '0;
                r_last_sample[i] <= '0;
                r_cnt_sample[i]  <= '0;
                r_speed_st[i]    <= '0;
            end
        end else begin
            r_state <= n_state;

            if (w_put) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    egsm_pkg::CFG_ENABLE_LEFT:  r_en_left   <= i_cfg_data[0];
                    egsm_pkg::CFG_ENABLE_RIGHT: r_en_right  <= i_cfg_data[0];
                    egsm_pkg::CFG_LOCKOUT_US:   r_lockout   <= i_cfg_data;
                    egsm_pkg::CFG_SAMPLE_MS:    r_sample_ms <= i_cfg_data[egsm_pkg::SAMPLE_W-1:0];
                    egsm_pkg::CFG_GAPS_Q8:      r_gaps_q8   <= i_cfg_data[egsm_pkg::GAPS_W-1:0];
                    egsm_pkg::CFG_SPEED_SCALE:  r_scale     <= i_cfg_data[egsm_pkg::SCALE_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_state == egsm_pkg::ST_EVAL && r_mode == egsm_pkg::MODE_EDGE) begin
                r_gap_cnt[r_ch] <= w_gap_next;
                if (w_enabled && w_pulse_ok) begin
                    r_last_pulse[r_ch] <= r_now_us;
                end
            end

            if (w_put && r_upd) begin
                r_speed_st[r_ch]    <= r_speed;
                r_last_sample[r_ch] <= r_now_ms;
                r_cnt_sample[r_ch]  <= r_gap;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_mode   <= i_in_item.mode;
            r_ch     <= w_ch_idx;
            r_now_us <= i_in_item.now_us;
            r_now_ms <= i_in_item.now_ms;
        end

        unique case (r_state)
            egsm_pkg::ST_EVAL: begin
                r_gap   <= w_gap_next;
                r_speed <= r_speed_st[r_ch];
                r_upd   <= w_need_div;
                r_delta <= w_gap_cur - w_cnt_cur;
                r_diff  <= w_diff_ms;
            end
            egsm_pkg::ST_MUL_NUM: begin
                r_num <= w_prod;
            end
            egsm_pkg::ST_MUL_DEN: begin
                r_den <= w_prod;
            end
            egsm_pkg::ST_CHK: begin
                // dividend = num << 16: high part seeds the remainder, the rest shifts in
                r_rem   <= {{egsm_pkg::SCALE_W{1'b0}},
                            r_num[egsm_pkg::PROD_W-1:egsm_pkg::SCALE_W]};
                r_quo   <= {r_num[egsm_pkg::SCALE_W-1:0], {egsm_pkg::SCALE_W{1'b0}}};
                r_cnt   <= '0;
                if (w_sat) begin
                    r_speed <= '1;
                end
            end
            egsm_pkg::ST_DIV: begin
                r_rem <= w_ge ? w_sub[egsm_pkg::PROD_W-1:0] : w_shift[egsm_pkg::PROD_W-1:0];
                r_quo <= {r_quo[egsm_pkg::QUOT_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (w_div_last) begin
                    r_speed <= {r_quo[egsm_pkg::QUOT_W-2:0], w_ge};
                end
            end
            default: begin
            end
        endcase

        if (w_put) begin
            r_out.result_channel <= r_ch[0];
            r_out.speed_q8       <= r_speed;
            r_out.gap_count      <= r_gap;
            r_out.speed_updated  <= r_upd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == egsm_pkg::ST_EVAL))
        else $error("accepted transaction did not enter evaluation");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == egsm_pkg::ST_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_put_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_put |=> (o_out_valid && r_state == egsm_pkg::ST_IDLE))
        else $error("result not loaded into output register");

    a_zero_den_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == egsm_pkg::ST_CHK && r_den == '0) |=>
        (r_speed == '1 && r_state == egsm_pkg::ST_PUT))
        else $error("zero divisor did not saturate");

endmodule
